// ===== design/fsq_pkg.sv =====
package fsq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int NUM_LEVELS      = 4;
    localparam int OCC_W           = 5;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [2:0] ST_ENQ      = 3'd0;
    localparam logic [2:0] ST_DEQ      = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_BADLABEL = 3'd4;

    localparam logic [7:0] LABEL_C = 8'h43;
    localparam logic [7:0] LABEL_H = 8'h48;
    localparam logic [7:0] LABEL_M = 8'h4D;
    localparam logic [7:0] LABEL_N = 8'h4E;

    typedef logic [1:0] level_t;

    localparam level_t LVL_N = 2'd0;
    localparam level_t LVL_M = 2'd1;
    localparam level_t LVL_H = 2'd2;
    localparam level_t LVL_C = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    typedef struct packed {
        logic        op;
        logic [7:0]  label;
        logic [15:0] arrival;
        logic [7:0]  developer;
        logic [15:0] start_time;
        logic [15:0] duration;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       out_label;
        logic [15:0]      out_arrival;
        logic [7:0]       out_developer;
        logic [15:0]      out_start_time;
        logic [15:0]      out_duration;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

    typedef struct packed {
        level_t      lvl;
        logic [15:0] arrival;
        logic [7:0]  developer;
        logic [15:0] start_time;
        logic [15:0] duration;
    } entry_t;

    typedef struct packed {
        logic   known;
        level_t lvl;
    } lbl_t;

    typedef struct packed {
        logic   push;
        logic   pop;
        level_t push_lvl;
    } lvl_cmd_t;

    typedef struct packed {
        logic   empty;
        logic   full;
        level_t top_lvl;
    } lvl_stat_t;

    function automatic lbl_t label_decode(input logic [7:0] label);
        lbl_t r;
        r.known = 1'b1;
        case (label)
            LABEL_C: r.lvl = LVL_C;
            LABEL_H: r.lvl = LVL_H;
            LABEL_M: r.lvl = LVL_M;
            LABEL_N: r.lvl = LVL_N;
            default:
            begin
                r.known = 1'b0;
                r.lvl   = LVL_N;
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] level_label(input level_t lvl);
        logic [7:0] r;
        case (lvl)
            LVL_C:   r = LABEL_C;
            LVL_H:   r = LABEL_H;
            LVL_M:   r = LABEL_M;
            default: r = LABEL_N;
        endcase
        return r;
    endfunction

endpackage

// ===== design/fsq_mem.sv =====
module fsq_mem #(
    parameter int ADDR_W = 6
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  fsq_pkg::entry_t       wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output fsq_pkg::entry_t       rd_data
);

    localparam int WORDS = 1 << ADDR_W;

    fsq_pkg::entry_t mem [WORDS];
    fsq_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/fsq_lvl.sv =====
module fsq_lvl #(
    parameter int QUEUE_DEPTH = fsq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fsq_pkg::lvl_cmd_t                  cmd,
    output fsq_pkg::lvl_stat_t                 stat,
    output logic [$clog2(QUEUE_DEPTH)-1:0]     tail_ptr,
    output logic [$clog2(QUEUE_DEPTH)-1:0]     head_ptr,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    logic [PW-1:0] head_reg [fsq_pkg::NUM_LEVELS];
    logic [PW-1:0] head_next [fsq_pkg::NUM_LEVELS];
    logic [PW-1:0] tail_reg [fsq_pkg::NUM_LEVELS];
    logic [PW-1:0] tail_next [fsq_pkg::NUM_LEVELS];
    logic [CW-1:0] lcnt_reg [fsq_pkg::NUM_LEVELS];
    logic [CW-1:0] lcnt_next [fsq_pkg::NUM_LEVELS];
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [fsq_pkg::NUM_LEVELS-1:0] busy;
    fsq_pkg::level_t top_lvl;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PW'(1);
    endfunction

    always_comb
    begin
        for (int i = 0; i < fsq_pkg::NUM_LEVELS; i++)
        begin
            busy[i] = (lcnt_reg[i] != '0);
        end
        if (busy[3])
            top_lvl = fsq_pkg::LVL_C;
        else if (busy[2])
            top_lvl = fsq_pkg::LVL_H;
        else if (busy[1])
            top_lvl = fsq_pkg::LVL_M;
        else
            top_lvl = fsq_pkg::LVL_N;
    end

    // Each level is a circular FIFO; the front of the whole queue is the
    // head of the highest level that holds anything.
    always_comb
    begin
        for (int i = 0; i < fsq_pkg::NUM_LEVELS; i++)
        begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
            lcnt_next[i] = lcnt_reg[i];
            if (cmd.push && (cmd.push_lvl == fsq_pkg::level_t'(i)))
            begin
                tail_next[i] = ptr_inc(tail_reg[i]);
                lcnt_next[i] = lcnt_reg[i] + CW'(1);
            end
            else if (cmd.pop && (top_lvl == fsq_pkg::level_t'(i)))
            begin
                head_next[i] = ptr_inc(head_reg[i]);
                lcnt_next[i] = lcnt_reg[i] - CW'(1);
            end
        end
        if (cmd.push)
            cnt_next = cnt_reg + CW'(1);
        else if (cmd.pop)
            cnt_next = cnt_reg - CW'(1);
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fsq_pkg::NUM_LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                lcnt_reg[i] <= '0;
            end
            cnt_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < fsq_pkg::NUM_LEVELS; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
                lcnt_reg[i] <= lcnt_next[i];
            end
            cnt_reg <= cnt_next;
        end
    end

    assign stat.empty   = (cnt_reg == '0);
    assign stat.full    = (cnt_reg == FULL_CNT);
    assign stat.top_lvl = top_lvl;
    assign tail_ptr     = tail_reg[cmd.push_lvl];
    assign head_ptr     = head_reg[top_lvl];
    assign count        = cnt_reg;

endmodule

// ===== design/four_level_stable_priority_queue.sv =====
// Stable four-level priority queue of task records. Records live in one
// synchronous memory split into four circular FIFOs, one per level (C, H,
// M, N), so a dequeue always returns the oldest record of the highest level
// present. An enqueue, and any transaction that is rejected (unknown label,
// full store, empty store), has its response registered at the edge that
// accepts it. A successful dequeue reads the record memory at that edge,
// and the read data moves from S_READ into the response, which sits in an
// output register, once that register is free. A new request is taken only
// in S_IDLE when that register is free, so a pending response not yet taken
// holds off the next request. No clearing pass is needed after reset.
module four_level_stable_priority_queue #(
    parameter int QUEUE_DEPTH = fsq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  fsq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output fsq_pkg::rsp_t rsp
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = PW + 2;

    fsq_pkg::state_t    state_reg;
    fsq_pkg::state_t    state_next;
    fsq_pkg::lbl_t      lbl;
    fsq_pkg::lvl_cmd_t  cmd;
    fsq_pkg::lvl_stat_t stat;
    fsq_pkg::entry_t    wr_data;
    fsq_pkg::entry_t    rd_data;
    fsq_pkg::rsp_t      rsp_reg;
    fsq_pkg::rsp_t      rsp_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic               rsp_load;
    logic               out_free;
    logic               accept;
    logic               enq_ok;
    logic               deq_ok;
    logic [PW-1:0]      tail_ptr;
    logic [PW-1:0]      head_ptr;
    logic [CW-1:0]      count;
    logic [CW-1:0]      occ_now;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;

    assign lbl      = fsq_pkg::label_decode(req.label);
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign accept   = req_valid && req_ready;
    assign enq_ok   = (req.op == fsq_pkg::OP_ENQ) && lbl.known && !stat.full;
    assign deq_ok   = (req.op == fsq_pkg::OP_DEQ) && !stat.empty;

    assign cmd.push     = accept && enq_ok;
    assign cmd.pop      = accept && deq_ok;
    assign cmd.push_lvl = lbl.lvl;

    assign wr_data.lvl        = lbl.lvl;
    assign wr_data.arrival    = req.arrival;
    assign wr_data.developer  = req.developer;
    assign wr_data.start_time = req.start_time;
    assign wr_data.duration   = req.duration;
    assign wr_addr            = {lbl.lvl, tail_ptr};
    assign rd_addr            = {stat.top_lvl, head_ptr};
    assign occ_now            = count + CW'(enq_ok);

    fsq_lvl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_lvl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .tail_ptr (tail_ptr),
        .head_ptr (head_ptr),
        .count    (count)
    );

    fsq_mem #(
        .ADDR_W (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.pop),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fsq_pkg::S_IDLE:
            begin
                if (cmd.pop)
                    state_next = fsq_pkg::S_READ;
            end
            fsq_pkg::S_READ:
            begin
                if (out_free)
                    state_next = fsq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = fsq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        rsp_load  = 1'b0;
        rsp_next  = '0;
        case (state_reg)
            fsq_pkg::S_IDLE:
            begin
                req_ready = out_free;
                // A successful dequeue answers from the memory read data, loaded in S_READ.
                rsp_load  = accept && !deq_ok;
                if (req.op == fsq_pkg::OP_DEQ)
                    rsp_next.status = fsq_pkg::ST_EMPTY;
                else if (!lbl.known)
                    rsp_next.status = fsq_pkg::ST_BADLABEL;
                else if (stat.full)
                    rsp_next.status = fsq_pkg::ST_FULL;
                else
                    rsp_next.status = fsq_pkg::ST_ENQ;
                rsp_next.occupancy = fsq_pkg::OCC_W'(occ_now);
            end
            fsq_pkg::S_READ:
            begin
                rsp_load                = out_free;
                rsp_next.status         = fsq_pkg::ST_DEQ;
                rsp_next.out_label      = fsq_pkg::level_label(rd_data.lvl);
                rsp_next.out_arrival    = rd_data.arrival;
                rsp_next.out_developer  = rd_data.developer;
                rsp_next.out_start_time = rd_data.start_time;
                rsp_next.out_duration   = rd_data.duration;
                rsp_next.occupancy      = fsq_pkg::OCC_W'(count);
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (rsp_load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fsq_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(QUEUE_DEPTH))
        else $error("stored record count exceeds the queue depth");

    a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> (state_reg == fsq_pkg::S_READ) && !req_ready)
        else $error("dequeue did not wait for the memory read");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.push && !cmd.pop |=> $stable(count))
        else $error("record count changed without a push or pop");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.status != fsq_pkg::ST_DEQ) |->
            (rsp_reg.out_label == '0) && (rsp_reg.out_arrival == '0) &&
            (rsp_reg.out_developer == '0) && (rsp_reg.out_start_time == '0) &&
            (rsp_reg.out_duration == '0))
        else $error("non-dequeue response carries record fields");

endmodule
